// File: design/lfd_pkg.sv
// Shared constants, types and tables for the line-follow drive with odometry.
package lfd_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [9:0] STEP_TIME_RST = 10'd32;

    localparam logic [9:0] DARK_CENTER_LIM = 10'd350;
    localparam logic [9:0] BRIGHT_SIDE_LIM = 10'd400;
    localparam logic [9:0] ALL_DARK_LIM    = 10'd500;
    localparam logic [9:0] SIDE_DARK_LIM   = 10'd650;

    localparam logic signed [13:0] SPEED_FAST = 14'sd7717;
    localparam logic signed [13:0] SPEED_TURN = 14'sd5145;
    localparam logic signed [13:0] SPEED_BACK = -14'sd1286;
    localparam logic signed [13:0] SPEED_ZERO = 14'sd0;

    // (vR + vL) * 18712 split into whole multiples of 490625 and the remainder
    localparam logic [9:0]  DS_WHOLE_FAST = 10'd588;
    localparam logic [18:0] DS_FRAC_FAST  = 19'd313508;
    localparam logic [9:0]  DS_WHOLE_TURN = 10'd147;
    localparam logic [18:0] DS_FRAC_TURN  = 19'd87733;
    localparam logic [28:0] DS_HALF       = 29'd245312;
    // ceil(2^48 / 490625)
    localparam logic [29:0] DS_RECIP      = 30'd573706959;

    // |vR - vL| * 3842950 for the turning modes
    localparam logic [44:0] DTH_GAIN = 45'd24714011450;
    localparam logic [44:0] DTH_HALF = 45'd32768;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [31:0] EAST_RST  = 32'd3305112;
    localparam logic [31:0] NORTH_RST = 32'd11374932;

    typedef enum logic [1:0] {
        DRV_STOP,
        DRV_FAST,
        DRV_RIGHT,
        DRV_LEFT
    } drive_t;

    function automatic logic signed [13:0] left_speed_of(input drive_t m);
        logic signed [13:0] v;
        case (m)
            DRV_FAST:  v = SPEED_FAST;
            DRV_RIGHT: v = SPEED_TURN;
            DRV_LEFT:  v = SPEED_BACK;
            default:   v = SPEED_ZERO;
        endcase
        return v;
    endfunction

    function automatic logic signed [13:0] right_speed_of(input drive_t m);
        logic signed [13:0] v;
        case (m)
            DRV_FAST:  v = SPEED_FAST;
            DRV_RIGHT: v = SPEED_BACK;
            DRV_LEFT:  v = SPEED_TURN;
            default:   v = SPEED_ZERO;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] atan_at(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2E;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000028;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000002;
            5'd29:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// File: design/lfd_if.sv
// Valid/ready channel interfaces for ground readings and drive results.
interface lfd_ground_if;
    logic       valid;
    logic       ready;
    logic [9:0] left_ground;
    logic [9:0] center_ground;
    logic [9:0] right_ground;

    modport source (output valid, output left_ground, output center_ground,
                    output right_ground, input ready);
    modport sink   (input valid, input left_ground, input center_ground,
                    input right_ground, output ready);
endinterface

interface lfd_result_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] left_speed;
    logic signed [13:0] right_speed;
    logic               all_dark;
    logic signed [31:0] pose_east;
    logic signed [31:0] pose_north;
    logic        [31:0] heading;

    modport source (output valid, output left_speed, output right_speed,
                    output all_dark, output pose_east, output pose_north,
                    output heading, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input all_dark, input pose_east, input pose_north,
                    input heading, output ready);
endinterface

// File: design/line_follow_drive_with_odometry.sv
// Line-follow drive controller with CORDIC-based dead-reckoning odometry.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   ground   | in  | valid/ready        | left_ground, center_ground, right_ground
//   result   | out | valid/ready        | speeds, all_dark, pose_east/north, heading
//   cfg      | in  | cfg_wr_en          | cfg_wr_data = step_time_ms
//
// One transfer runs through the states in order until ground.ready returns: distance in S_LOAD
// and S_DIV (wheel-sum products, then a reciprocal multiply for the divide), CORDIC_STEPS
// rotations, then a shared multiplier for north and east, the heading update and the output load.
// Reset restores the start pose and a 32 ms step; no clearing pass.
// The output register lets a new transfer start while a result is still held;
// a finished item waits in its last state until that register is free.
module line_follow_drive_with_odometry #(
    parameter int CORDIC_STEPS = lfd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [9:0]          cfg_wr_data,
    lfd_ground_if.sink          ground,
    lfd_result_if.source        result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_ROT,
        S_QUAD,
        S_MULN,
        S_ADDN,
        S_MULE,
        S_ADDE,
        S_TURN,
        S_HEAD,
        S_DONE
    } state_t;

    localparam logic [4:0] ROT_LAST = 5'(CORDIC_STEPS - 1);

    state_t               state_reg, state_next;
    lfd_pkg::drive_t      mode_reg, mode_next;
    logic                 dark_reg, dark_next;
    logic [9:0]           step_time_reg, step_time_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [28:0]          frac_reg, frac_next;
    logic [19:0]          whole_reg, whole_next;
    logic [19:0]          ds_reg, ds_next;
    logic signed [32:0]   x_reg, x_next;
    logic signed [32:0]   y_reg, y_next;
    logic signed [32:0]   z_reg, z_next;
    logic [1:0]           quad_reg, quad_next;
    logic signed [32:0]   cos_reg, cos_next;
    logic signed [32:0]   sin_reg, sin_next;
    logic signed [53:0]   prod_reg, prod_next;
    logic [31:0]          dth_reg, dth_next;
    logic [31:0]          east_reg, east_next;
    logic [31:0]          north_reg, north_next;
    logic [31:0]          heading_reg, heading_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [13:0]   out_left_reg, out_left_next;
    logic signed [13:0]   out_right_reg, out_right_next;
    logic                 out_dark_reg, out_dark_next;
    logic [31:0]          out_east_reg, out_east_next;
    logic [31:0]          out_north_reg, out_north_next;
    logic [31:0]          out_heading_reg, out_heading_next;

    logic                 in_xfer;
    logic [9:0]           ds_whole;
    logic [18:0]          ds_frac;
    logic [19:0]          whole_num;
    logic [28:0]          frac_num;
    logic [58:0]          recip_prod;
    logic [19:0]          ds_sum;
    logic signed [32:0]   rot_dx;
    logic signed [32:0]   rot_dy;
    logic signed [32:0]   rot_atan;
    logic signed [32:0]   mul_op;
    logic signed [53:0]   mul_prod;
    logic [53:0]          rnd_mag;
    logic [53:0]          rnd_sum;
    logic [31:0]          rnd_q;
    logic [31:0]          rnd_delta;
    logic [44:0]          dth_prod;
    logic [44:0]          dth_sum;
    logic [31:0]          dth_mag;

    assign in_xfer      = ground.valid && (state_reg == S_IDLE);
    assign ground.ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (mode_reg)
            lfd_pkg::DRV_FAST:
            begin
                ds_whole = lfd_pkg::DS_WHOLE_FAST;
                ds_frac  = lfd_pkg::DS_FRAC_FAST;
            end
            lfd_pkg::DRV_RIGHT, lfd_pkg::DRV_LEFT:
            begin
                ds_whole = lfd_pkg::DS_WHOLE_TURN;
                ds_frac  = lfd_pkg::DS_FRAC_TURN;
            end
            default:
            begin
                ds_whole = 10'd0;
                ds_frac  = 19'd0;
            end
        endcase
    end

    assign whole_num  = 20'(ds_whole) * 20'(step_time_reg);
    assign frac_num   = 29'(ds_frac) * 29'(step_time_reg) + lfd_pkg::DS_HALF;
    assign recip_prod = 59'(frac_reg) * 59'(lfd_pkg::DS_RECIP);
    assign ds_sum     = whole_reg + 20'(recip_prod[58:48]);

    assign rot_dx   = y_reg >>> cnt_reg;
    assign rot_dy   = x_reg >>> cnt_reg;
    assign rot_atan = $signed({1'b0, lfd_pkg::atan_at(cnt_reg)});

    assign mul_op   = (state_reg == S_MULE) ? sin_reg : cos_reg;
    assign mul_prod = $signed({1'b0, ds_reg}) * mul_op;

    assign rnd_mag   = prod_reg[53] ? 54'(-prod_reg) : 54'(prod_reg);
    assign rnd_sum   = rnd_mag + (54'd1 << 29);
    assign rnd_q     = {8'd0, rnd_sum[53:30]};
    assign rnd_delta = prod_reg[53] ? (32'd0 - rnd_q) : rnd_q;

    assign dth_prod = 45'(step_time_reg) * lfd_pkg::DTH_GAIN;
    assign dth_sum  = dth_prod + lfd_pkg::DTH_HALF;
    assign dth_mag  = {3'd0, dth_sum[44:16]};

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        dark_next        = dark_reg;
        step_time_next   = cfg_wr_en ? cfg_wr_data : step_time_reg;
        cnt_next         = cnt_reg;
        frac_next        = frac_reg;
        whole_next       = whole_reg;
        ds_next          = ds_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        quad_next        = quad_reg;
        cos_next         = cos_reg;
        sin_next         = sin_reg;
        prod_next        = prod_reg;
        dth_next         = dth_reg;
        east_next        = east_reg;
        north_next       = north_reg;
        heading_next     = heading_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_left_next    = out_left_reg;
        out_right_next   = out_right_reg;
        out_dark_next    = out_dark_reg;
        out_east_next    = out_east_reg;
        out_north_next   = out_north_reg;
        out_heading_next = out_heading_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    dark_next = 1'b0;
                    if (ground.center_ground < lfd_pkg::DARK_CENTER_LIM &&
                        ground.left_ground > lfd_pkg::BRIGHT_SIDE_LIM &&
                        ground.right_ground > lfd_pkg::BRIGHT_SIDE_LIM)
                    begin
                        mode_next = lfd_pkg::DRV_FAST;
                    end
                    else if (ground.left_ground < lfd_pkg::ALL_DARK_LIM &&
                             ground.center_ground < lfd_pkg::ALL_DARK_LIM &&
                             ground.right_ground < lfd_pkg::ALL_DARK_LIM)
                    begin
                        mode_next = lfd_pkg::DRV_FAST;
                        dark_next = 1'b1;
                    end
                    else if (ground.right_ground < lfd_pkg::SIDE_DARK_LIM)
                    begin
                        mode_next = lfd_pkg::DRV_RIGHT;
                    end
                    else if (ground.left_ground < lfd_pkg::SIDE_DARK_LIM)
                    begin
                        mode_next = lfd_pkg::DRV_LEFT;
                    end
                    x_next     = lfd_pkg::CORDIC_GAIN;
                    y_next     = 33'sd0;
                    z_next     = $signed({3'd0, heading_reg[29:0]});
                    quad_next  = heading_reg[31:30];
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                whole_next = whole_num;
                frac_next  = frac_num;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ds_next    = ds_sum;
                cnt_next   = 5'd0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!z_reg[32])
                begin
                    x_next = x_reg - rot_dx;
                    y_next = y_reg + rot_dy;
                    z_next = z_reg - rot_atan;
                end
                else
                begin
                    x_next = x_reg + rot_dx;
                    y_next = y_reg - rot_dy;
                    z_next = z_reg + rot_atan;
                end
                if (cnt_reg == ROT_LAST)
                begin
                    state_next = S_QUAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_QUAD:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        cos_next = x_reg;
                        sin_next = y_reg;
                    end
                    2'd1:
                    begin
                        cos_next = -y_reg;
                        sin_next = x_reg;
                    end
                    2'd2:
                    begin
                        cos_next = -x_reg;
                        sin_next = -y_reg;
                    end
                    default:
                    begin
                        cos_next = y_reg;
                        sin_next = -x_reg;
                    end
                endcase
                state_next = S_MULN;
            end
            S_MULN:
            begin
                prod_next  = mul_prod;
                state_next = S_ADDN;
            end
            S_ADDN:
            begin
                north_next = north_reg + rnd_delta;
                state_next = S_MULE;
            end
            S_MULE:
            begin
                prod_next  = mul_prod;
                state_next = S_ADDE;
            end
            S_ADDE:
            begin
                east_next  = east_reg + rnd_delta;
                state_next = S_TURN;
            end
            S_TURN:
            begin
                case (mode_reg)
                    lfd_pkg::DRV_LEFT:  dth_next = dth_mag;
                    lfd_pkg::DRV_RIGHT: dth_next = 32'd0 - dth_mag;
                    default:            dth_next = 32'd0;
                endcase
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                heading_next = heading_reg + dth_reg;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_left_next    = lfd_pkg::left_speed_of(mode_reg);
                    out_right_next   = lfd_pkg::right_speed_of(mode_reg);
                    out_dark_next    = dark_reg;
                    out_east_next    = east_reg;
                    out_north_next   = north_reg;
                    out_heading_next = heading_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= lfd_pkg::DRV_STOP;
            dark_reg        <= 1'b0;
            step_time_reg   <= lfd_pkg::STEP_TIME_RST;
            cnt_reg         <= 5'd0;
            frac_reg        <= 29'd0;
            whole_reg       <= 20'd0;
            ds_reg          <= 20'd0;
            x_reg           <= 33'sd0;
            y_reg           <= 33'sd0;
            z_reg           <= 33'sd0;
            quad_reg        <= 2'd0;
            cos_reg         <= 33'sd0;
            sin_reg         <= 33'sd0;
            prod_reg        <= 54'sd0;
            dth_reg         <= 32'd0;
            east_reg        <= lfd_pkg::EAST_RST;
            north_reg       <= lfd_pkg::NORTH_RST;
            heading_reg     <= 32'd0;
            out_valid_reg   <= 1'b0;
            out_left_reg    <= 14'sd0;
            out_right_reg   <= 14'sd0;
            out_dark_reg    <= 1'b0;
            out_east_reg    <= 32'd0;
            out_north_reg   <= 32'd0;
            out_heading_reg <= 32'd0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            dark_reg        <= dark_next;
            step_time_reg   <= step_time_next;
            cnt_reg         <= cnt_next;
            frac_reg        <= frac_next;
            whole_reg       <= whole_next;
            ds_reg          <= ds_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            z_reg           <= z_next;
            quad_reg        <= quad_next;
            cos_reg         <= cos_next;
            sin_reg         <= sin_next;
            prod_reg        <= prod_next;
            dth_reg         <= dth_next;
            east_reg        <= east_next;
            north_reg       <= north_next;
            heading_reg     <= heading_next;
            out_valid_reg   <= out_valid_next;
            out_left_reg    <= out_left_next;
            out_right_reg   <= out_right_next;
            out_dark_reg    <= out_dark_next;
            out_east_reg    <= out_east_next;
            out_north_reg   <= out_north_next;
            out_heading_reg <= out_heading_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_speed  = out_left_reg;
    assign result.right_speed = out_right_reg;
    assign result.all_dark    = out_dark_reg;
    assign result.pose_east   = $signed(out_east_reg);
    assign result.pose_north  = $signed(out_north_reg);
    assign result.heading     = out_heading_reg;

endmodule

// File: design/lfd_checker.sv
// Port-level assertions for the line-follow drive, bound to the top level.
module lfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [13:0] left_speed,
    input logic signed [13:0] right_speed,
    input logic               all_dark,
    input logic signed [31:0] pose_east,
    input logic signed [31:0] pose_north,
    input logic        [31:0] heading
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // busy after an input transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input ready right after a transfer");

    // a result appears only as the block finishes an item
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while the block was idle");

    a_dark_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && all_dark) |->
            (left_speed == lfd_pkg::SPEED_FAST && right_speed == lfd_pkg::SPEED_FAST))
        else $error("all-dark flag without straight-ahead speeds");

    a_speed_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((left_speed == lfd_pkg::SPEED_ZERO && right_speed == lfd_pkg::SPEED_ZERO) ||
             (left_speed == lfd_pkg::SPEED_FAST && right_speed == lfd_pkg::SPEED_FAST) ||
             (left_speed == lfd_pkg::SPEED_TURN && right_speed == lfd_pkg::SPEED_BACK) ||
             (left_speed == lfd_pkg::SPEED_BACK && right_speed == lfd_pkg::SPEED_TURN)))
        else $error("wheel speeds not a known drive pair");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(left_speed) && $stable(right_speed) && $stable(all_dark)
             && $stable(pose_east) && $stable(pose_north) && $stable(heading)))
        else $error("stalled result changed");

endmodule

bind line_follow_drive_with_odometry lfd_checker u_lfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (ground.valid),
    .in_ready    (ground.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .left_speed  (result.left_speed),
    .right_speed (result.right_speed),
    .all_dark    (result.all_dark),
    .pose_east   (result.pose_east),
    .pose_north  (result.pose_north),
    .heading     (result.heading)
);

// File: tb/sv/line_follow_drive_with_odometry_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line-follow drive: predicts speeds, pose and heading per step.
module line_follow_drive_with_odometry_test;

    typedef struct {
        logic signed [13:0] left_speed;
        logic signed [13:0] right_speed;
        logic               all_dark;
        logic signed [31:0] pose_east;
        logic signed [31:0] pose_north;
        logic        [31:0] heading;
    } drive_result_t;

    typedef struct {
        logic [9:0] left_ground;
        logic [9:0] center_ground;
        logic [9:0] right_ground;
    } ground_reading_t;

    class odometry_scoreboard;
        localparam longint FAST_RAD = 7717;
        localparam longint TURN_RAD = 5145;
        localparam longint BACK_RAD = -1286;
        localparam longint DIST_NUM = 18712;
        localparam longint DIST_DEN = 490625;
        localparam longint TURN_NUM = 3842950;
        localparam longint TURN_DEN = 65536;
        localparam longint UNIT_Q30 = 1073741824;
        localparam longint ROT_START = 652032874;
        localparam int ROT_ITERS = lfd_pkg::CORDIC_STEPS_DEF;
        localparam logic [31:0] ARCTAN [0:29] = '{
            32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
            32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
        };

        logic [9:0]      step_time_ms;
        lfd_pkg::drive_t mode;
        logic [31:0]     east;
        logic [31:0]     north;
        logic [31:0]     angle;
        drive_result_t   pending[$];
        int unsigned     failures;

        function new();
            step_time_ms = 10'd32;
            mode = lfd_pkg::DRV_STOP;
            east = 32'd3305112;
            north = 32'd11374932;
            angle = 32'd0;
            failures = 0;
        endfunction

        function void set_step_time(logic [9:0] t);
            step_time_ms = t;
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint wheel_speed(lfd_pkg::drive_t m, bit right_side);
            longint v;
            case (m)
                lfd_pkg::DRV_FAST:  v = FAST_RAD;
                lfd_pkg::DRV_RIGHT: v = right_side ? BACK_RAD : TURN_RAD;
                lfd_pkg::DRV_LEFT:  v = right_side ? TURN_RAD : BACK_RAD;
                default:            v = 0;
            endcase
            return v;
        endfunction

        function void rotate(input logic [31:0] ang, output longint c, output longint s);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            int i;
            x = ROT_START;
            y = 0;
            z = {34'd0, ang[29:0]};
            for (i = 0; i < ROT_ITERS && i < 30; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= {32'd0, ARCTAN[i]};
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += {32'd0, ARCTAN[i]};
                end
            end
            case (ang[31:30])
                2'd0:    begin c = x;  s = y;  end
                2'd1:    begin c = -y; s = x;  end
                2'd2:    begin c = -x; s = -y; end
                default: begin c = y;  s = -x; end
            endcase
        endfunction

        function void note_reading(logic [9:0] l, logic [9:0] c, logic [9:0] r);
            logic          dark;
            longint        vl;
            longint        vr;
            longint        t;
            longint        ds;
            longint        dth;
            longint        cs;
            longint        sn;
            drive_result_t res;
            dark = 1'b0;
            if (c < 350 && l > 400 && r > 400)
                mode = lfd_pkg::DRV_FAST;
            else if (l < 500 && c < 500 && r < 500)
            begin
                mode = lfd_pkg::DRV_FAST;
                dark = 1'b1;
            end
            else if (r < 650)
                mode = lfd_pkg::DRV_RIGHT;
            else if (l < 650)
                mode = lfd_pkg::DRV_LEFT;
            vl = wheel_speed(mode, 1'b0);
            vr = wheel_speed(mode, 1'b1);
            t = {54'd0, step_time_ms};
            ds = round_div((vr + vl) * t * DIST_NUM, DIST_DEN);
            dth = round_div((vr - vl) * t * TURN_NUM, TURN_DEN);
            rotate(angle, cs, sn);
            north += 32'(round_div(ds * cs, UNIT_Q30));
            east += 32'(round_div(ds * sn, UNIT_Q30));
            angle += 32'(dth);
            res.left_speed = 14'(vl);
            res.right_speed = 14'(vr);
            res.all_dark = dark;
            res.pose_east = east;
            res.pose_north = north;
            res.heading = angle;
            pending.push_back(res);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(drive_result_t got);
            drive_result_t want;
            if (pending.size() == 0)
            begin
                $error("result transfer with no reading pending");
                failures++;
                return;
            end
            want = pending.pop_front();
            compare("left_speed", want.left_speed, got.left_speed);
            compare("right_speed", want.right_speed, got.right_speed);
            compare("all_dark", want.all_dark, got.all_dark);
            compare("pose_east", want.pose_east, got.pose_east);
            compare("pose_north", want.pose_north, got.pose_north);
            compare("heading", want.heading, got.heading);
        endfunction
    endclass

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [9:0] cfg_wr_data;

    lfd_ground_if ground ();
    lfd_result_if result ();

    odometry_scoreboard sb;
    int quiet_cycles;

    line_follow_drive_with_odometry dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ground      (ground),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_reading(input logic [9:0] l, input logic [9:0] c, input logic [9:0] r);
        @(negedge clk);
        ground.valid <= 1'b1;
        ground.left_ground <= l;
        ground.center_ground <= c;
        ground.right_ground <= r;
        do
            @(posedge clk);
        while (!ground.ready);
        sb.note_reading(l, c, r);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            ground.valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        pause_sender(1);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_step_time(input logic [9:0] t);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        sb.set_step_time(t);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [9:0] near_threshold();
        logic [9:0] marks [0:11];
        marks = '{10'd349, 10'd350, 10'd351, 10'd399, 10'd400, 10'd401,
                  10'd499, 10'd500, 10'd501, 10'd649, 10'd650, 10'd651};
        return marks[$urandom_range(0, 11)];
    endfunction

    function automatic ground_reading_t random_reading();
        ground_reading_t g;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                g.center_ground = 10'($urandom_range(0, 349));
                g.left_ground = 10'($urandom_range(401, 1023));
                g.right_ground = 10'($urandom_range(401, 1023));
            end
            2:
            begin
                g.left_ground = 10'($urandom_range(0, 499));
                g.center_ground = 10'($urandom_range(0, 499));
                g.right_ground = 10'($urandom_range(0, 499));
            end
            3, 4:
            begin
                g.left_ground = 10'($urandom_range(0, 1023));
                g.center_ground = 10'($urandom_range(0, 1023));
                g.right_ground = 10'($urandom_range(0, 649));
            end
            5, 6:
            begin
                g.left_ground = 10'($urandom_range(0, 649));
                g.center_ground = 10'($urandom_range(0, 1023));
                g.right_ground = 10'($urandom_range(650, 1023));
            end
            7:
            begin
                g.left_ground = 10'($urandom_range(650, 1023));
                g.center_ground = 10'($urandom_range(350, 1023));
                g.right_ground = 10'($urandom_range(650, 1023));
            end
            8:
            begin
                g.left_ground = near_threshold();
                g.center_ground = near_threshold();
                g.right_ground = near_threshold();
            end
            default:
            begin
                g.left_ground = 10'($urandom_range(0, 1023));
                g.center_ground = 10'($urandom_range(0, 1023));
                g.right_ground = 10'($urandom_range(0, 1023));
            end
        endcase
        return g;
    endfunction

    task automatic run_bursts(input int count);
        int sent;
        int burst;
        ground_reading_t g;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    g = random_reading();
                    send_reading(g.left_ground, g.center_ground, g.right_ground);
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 60));
        end
    endtask

    // Receiver stall pattern: runs of always-ready, random, mostly-ready or stalled.
    initial
    begin
        int kind;
        int run;
        result.ready = 1'b0;
        forever
        begin
            kind = $urandom_range(0, 4);
            run = (kind == 4) ? $urandom_range(20, 120) : $urandom_range(1, 40);
            repeat (run)
            begin
                @(negedge clk);
                case (kind)
                    0:       result.ready <= 1'b1;
                    1:       result.ready <= 1'($urandom_range(0, 1));
                    2:       result.ready <= ($urandom_range(0, 3) != 0);
                    default: result.ready <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        drive_result_t got;
        if (result.valid && result.ready)
        begin
            got.left_speed = result.left_speed;
            got.right_speed = result.right_speed;
            got.all_dark = result.all_dark;
            got.pose_east = result.pose_east;
            got.pose_north = result.pose_north;
            got.heading = result.heading;
            sb.check_result(got);
        end
        if ((ground.valid && ground.ready) || (result.valid && result.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("line_follow_drive_with_odometry_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int p;
        logic [9:0] step_times [0:5];
        int counts [0:5];
        sb = new();
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 10'd0;
        ground.valid = 1'b0;
        ground.left_ground = 10'd0;
        ground.center_ground = 10'd0;
        ground.right_ground = 10'd0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_reading(10'd0, 10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023, 10'd1023);
        send_reading(10'd1023, 10'd0, 10'd1023);
        send_reading(10'd450, 10'd100, 10'd450);
        send_reading(10'd499, 10'd499, 10'd499);
        send_reading(10'd500, 10'd499, 10'd499);
        send_reading(10'd1023, 10'd1023, 10'd1023);
        send_reading(10'd1023, 10'd1023, 10'd649);
        send_reading(10'd649, 10'd1023, 10'd650);
        send_reading(10'd650, 10'd1023, 10'd650);
        send_reading(10'd401, 10'd349, 10'd401);
        send_reading(10'd400, 10'd349, 10'd401);
        send_reading(10'd401, 10'd350, 10'd401);
        send_reading(10'd1023, 10'd349, 10'd400);
        send_reading(10'd0, 10'd1023, 10'd0);
        send_reading(10'd1023, 10'd0, 10'd0);
        send_reading(10'd0, 10'd0, 10'd1023);
        send_reading(10'd682, 10'd341, 10'd682);
        send_reading(10'd341, 10'd682, 10'd341);
        drain();

        // zero step time: speeds change, pose and heading hold
        write_step_time(10'd0);
        send_reading(10'd1023, 10'd0, 10'd1023);
        send_reading(10'd1023, 10'd1023, 10'd0);
        drain();

        step_times = '{10'd1000, 10'd1, 10'd1023, 10'($urandom_range(2, 999)), 10'd0,
                       10'($urandom_range(0, 1023))};
        counts = '{250, 200, 250, 250, 100, 200};
        for (p = 0; p < 6; p++)
        begin
            write_step_time(step_times[p]);
            run_bursts(counts[p]);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("line_follow_drive_with_odometry_test OK");
        else
            $display("line_follow_drive_with_odometry_test NOT OK");
        $finish;
    end

endmodule
